[src/masked_column_argmax_unit_macros.svh]
// Assertion macros for the RTL file masked_column_argmax_unit.sv
`ifndef MASKED_COLUMN_ARGMAX_UNIT_MACROS_SVH
`define MASKED_COLUMN_ARGMAX_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, ignored while reset is asserted
`define MCA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked property, also during reset
`define MCA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define MCA_ASSERT(label, clk, rst_n, prop)
`define MCA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/mca_pkg.sv]
package mca_pkg;

    localparam int SAMPLES     = 4096;
    localparam int SAMPLE_BITS = $clog2(SAMPLES);
    localparam int NODE_BITS   = 16;
    localparam int VALUE_BITS  = 32;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [NODE_BITS-1:0]   t_node;
    typedef logic [VALUE_BITS-1:0]  t_value;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // NaN: exponent all ones and non-zero mantissa
    function automatic logic is_nan(input t_value x);
        return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    endfunction

    // Unsigned key that follows IEEE order
    function automatic t_value order_key(input t_value x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    // Strict IEEE a > b; signed zeros equal, NaN never greater
    function automatic logic float_greater(input t_value a, input t_value b);
        logic zeros;
        zeros = ((a | b) & 32'h7fff_ffff) == 32'd0;
        return !is_nan(a) && !is_nan(b) && !zeros && (order_key(a) > order_key(b));
    endfunction

endpackage

[src/mca_in_if.sv]
interface mca_in_if;
    import mca_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_index;
    t_node   node_index;
    t_value  value_bits;
    logic    node_enabled;
    logic    last_node;

    modport source (output valid, sample_index, node_index, value_bits,
                    node_enabled, last_node, input ready);
    modport sink   (input valid, sample_index, node_index, value_bits,
                    node_enabled, last_node, output ready);
endinterface

[src/mca_out_if.sv]
interface mca_out_if;
    import mca_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_out;
    t_node   best_node;
    t_value  best_value_bits;

    modport source (output valid, sample_out, best_node, best_value_bits, input ready);
    modport sink   (input valid, sample_out, best_node, best_value_bits, output ready);
endinterface

[src/masked_column_argmax_unit.sv]
// Column-wise masked argmax over a stream of matrix elements.
// i_in (sink): one element per item, row-major; sample_index selects the
// column entry, node_enabled masks the element, last_node closes the column.
// o_out (source): one result item per last_node element, carrying the column,
// the node of its maximum and the maximum value bits; the entry is then reset
// to +0.0 / node 0.
// Throughput: one item per cycle, outside the clearing pass and stalls. Each item is
// registered together with a synchronous read of the 4096-entry column store, then
// compared and written back from the compare stage; a one-entry bypass covers back-to-back same columns.
// A closing item goes from the compare stage into the result register, which
// drives o_out until the result is taken.
// Reset: a clearing pass writes all 4096 entries, one per cycle, and i_in.ready
// stays low after reset is released until the pass ends.
// Stall: while a result waits on o_out, the block still takes items that give
// no result; an item with last_node waits in the compare stage, and input
// is held off until it can move into the result register.
`include "masked_column_argmax_unit_macros.svh"

module masked_column_argmax_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mca_in_if.sink     i_in,
    mca_out_if.source  o_out
);
    import mca_pkg::*;

    // column store
    t_value  mem_value [SAMPLES];
    t_node   mem_node  [SAMPLES];

    t_state  r_state, n_state;
    t_sample r_clr_addr, n_clr_addr;

    // compare stage
    logic    r_s1_valid;
    t_sample r_s1_sample;
    t_node   r_s1_node;
    t_value  r_s1_value;
    logic    r_s1_enabled;
    logic    r_s1_last;
    t_value  r_rd_value;
    t_node   r_rd_node;

    // bypass of the last write
    logic    r_fw_valid;
    t_sample r_fw_sample;
    t_value  r_fw_value;
    t_node   r_fw_node;

    // result register
    logic    r_out_valid;
    t_sample r_out_sample;
    t_node   r_out_node;
    t_value  r_out_value;

    logic    in_accept;
    logic    s1_fire;
    logic    out_free;
    logic    clearing;
    t_value  cur_value;
    t_node   cur_node;
    t_value  upd_value;
    t_node   upd_node;
    logic    wr_en;
    t_sample wr_addr;
    t_value  wr_value;
    t_node   wr_node;

    // clearing sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        clearing   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clearing   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == t_sample'(SAMPLES - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                clearing = 1'b0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // handshakes
    assign out_free  = !r_out_valid || o_out.ready;
    assign s1_fire   = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !clearing && (!r_s1_valid || s1_fire);
    assign in_accept = i_in.valid && i_in.ready;

    // current entry, with bypass of the write made as this item was read
    always_comb begin
        if (r_fw_valid && r_fw_sample == r_s1_sample) begin
            cur_value = r_fw_value;
            cur_node  = r_fw_node;
        end else begin
            cur_value = r_rd_value;
            cur_node  = r_rd_node;
        end
        if (r_s1_enabled && float_greater(r_s1_value, cur_value)) begin
            upd_value = r_s1_value;
            upd_node  = r_s1_node;
        end else begin
            upd_value = cur_value;
            upd_node  = cur_node;
        end
    end

    // write port: clearing pass or write-back (zero after a result)
    always_comb begin
        if (clearing) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_addr;
            wr_value = '0;
            wr_node  = '0;
        end else begin
            wr_en    = s1_fire;
            wr_addr  = r_s1_sample;
            wr_value = r_s1_last ? '0 : upd_value;
            wr_node  = r_s1_last ? '0 : upd_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_value[wr_addr] <= wr_value;
            mem_node[wr_addr]  <= wr_node;
        end
        if (in_accept) begin
            r_rd_value <= mem_value[i_in.sample_index];
            r_rd_node  <= mem_node[i_in.sample_index];
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (clearing) begin
                r_fw_valid <= 1'b0;
            end else if (s1_fire) begin
                r_fw_valid <= 1'b1;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample  <= i_in.sample_index;
            r_s1_node    <= i_in.node_index;
            r_s1_value   <= i_in.value_bits;
            r_s1_enabled <= i_in.node_enabled;
            r_s1_last    <= i_in.last_node;
        end
        if (s1_fire) begin
            r_fw_sample <= r_s1_sample;
            r_fw_value  <= wr_value;
            r_fw_node   <= wr_node;
        end
        if (s1_fire && r_s1_last) begin
            r_out_sample <= r_s1_sample;
            r_out_node   <= upd_node;
            r_out_value  <= upd_value;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sample_out      = r_out_sample;
    assign o_out.best_node       = r_out_node;
    assign o_out.best_value_bits = r_out_value;

    // no item enters during the clearing pass
    `MCA_ASSERT_ALWAYS(a_no_accept_clear, i_clk, !(clearing && i_in.ready))
    // a closing item always reaches the result register
    `MCA_ASSERT(a_last_to_out, i_clk, i_rst_n, (s1_fire && r_s1_last) |=> r_out_valid)
    // clearing pass ends after the last entry
    `MCA_ASSERT(a_clear_end, i_clk, i_rst_n,
        (clearing && r_clr_addr == t_sample'(SAMPLES - 1)) |=> !clearing)
    // a stalled closing item blocks the input
    `MCA_ASSERT(a_stall_block, i_clk, i_rst_n,
        (r_s1_valid && r_s1_last && !out_free) |-> !i_in.ready)

endmodule

[bench/masked_column_argmax_unit_tb.sv]
module masked_column_argmax_unit_tb;
    import mca_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mca_in_if  in_ch ();
    mca_out_if out_ch ();

    masked_column_argmax_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    typedef struct packed {
        t_sample sample;
        t_node   node;
        t_value  value;
    } t_column_result;

    always #5 i_clk = ~i_clk;

    // predictor state: one running maximum per column
    t_value         peak_value [SAMPLES];
    t_node          peak_node  [SAMPLES];
    t_column_result pending_results [$];

    int  errors = 0;
    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    bit  hold_off = 1'b0;
    int  hold_cycles = 0;

    // IEEE strict a > b on bit patterns
    function automatic bit fp_above(t_value a, t_value b);
        t_value ka;
        t_value kb;
        if ((a[30:23] == 8'hff && a[22:0] != 0) || (b[30:23] == 8'hff && b[22:0] != 0))
            return 1'b0;
        if (((a | b) & 32'h7fff_ffff) == 32'd0)
            return 1'b0;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        return ka > kb;
    endfunction

    // update the column entry for one element and queue any result
    function automatic void track_column(t_sample s, t_node n, t_value v, bit en, bit last);
        t_column_result r;
        if (en && fp_above(v, peak_value[s])) begin
            peak_value[s] = v;
            peak_node[s]  = n;
        end
        if (last) begin
            r.sample = s;
            r.node   = peak_node[s];
            r.value  = peak_value[s];
            pending_results.push_back(r);
            peak_value[s] = '0;
            peak_node[s]  = '0;
        end
    endfunction

    // stop offering; called before any wait that follows an item
    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    // offer one element and wait for it to be taken
    task automatic send_element(t_sample s, t_node n, t_value v, bit en, bit last);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_index <= s;
        in_ch.node_index   <= n;
        in_ch.value_bits   <= v;
        in_ch.node_enabled <= en;
        in_ch.last_node    <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_column(s, n, v, en, last);
    endtask

    // receiver readiness
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_off) begin
            hold_cycles <= 300;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99, 0) >= recv_gap_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_column_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result sample %0d", out_ch.sample_out);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.sample_out !== exp_r.sample) begin
                    $error("sample_out exp %0h got %0h", exp_r.sample, out_ch.sample_out);
                    errors++;
                end
                if (out_ch.best_node !== exp_r.node) begin
                    $error("best_node exp %0h got %0h", exp_r.node, out_ch.best_node);
                    errors++;
                end
                if (out_ch.best_value_bits !== exp_r.value) begin
                    $error("best_value_bits exp %0h got %0h", exp_r.value,
                           out_ch.best_value_bits);
                    errors++;
                end
            end
        end
    end

    function automatic t_value random_float();
        case ($urandom_range(7, 0))
            0: return 32'h7fc0_0000 | $urandom_range(255, 0);
            1: return {$urandom_range(1, 0) == 1, 31'd0};
            2: return {1'b0, 8'hff, 23'd0};
            3: return {1'b1, 8'hff, 23'd0};
            default: return $urandom();
        endcase
    endfunction

    // special values, extremes and masking on a few columns
    task automatic test_directed();
        send_element(12'd0, 16'd5, 32'h8000_0000, 1'b1, 1'b1);   // negative zero
        send_element(12'd1, 16'd1, 32'h7fc0_0001, 1'b1, 1'b0);   // NaN
        send_element(12'd1, 16'd2, 32'h3f80_0000, 1'b1, 1'b0);
        send_element(12'd1, 16'd3, 32'h3f80_0000, 1'b1, 1'b0);   // equal: no change
        send_element(12'd1, 16'hffff, 32'h7f80_0000, 1'b0, 1'b0); // masked
        send_element(12'd1, 16'hffff, 32'hbf80_0000, 1'b1, 1'b1);
        send_element(12'hfff, 16'hffff, 32'h7f7f_ffff, 1'b1, 1'b0);
        send_element(12'hfff, 16'h8000, 32'h7f80_0000, 1'b1, 1'b0);
        send_element(12'hfff, 16'd0, 32'hffff_ffff, 1'b1, 1'b1);
        send_element(12'd2, 16'd9, 32'h0000_0001, 1'b1, 1'b0);   // denormal
        send_element(12'd2, 16'd10, 32'hff80_0000, 1'b0, 1'b1);  // masked last
        send_element(12'd3, 16'd1, 32'hc000_0000, 1'b1, 1'b1);   // nothing above zero
        send_element(12'd3, 16'd4, 32'h7fff_ffff, 1'b1, 1'b1);
    endtask

    // matrices of small widths and random node counts
    task automatic test_random(int n_items);
        int sent = 0;
        int width;
        int base;
        int rows;
        while (sent < n_items) begin
            width = $urandom_range(6, 1);
            base  = $urandom_range(SAMPLES - width, 0);
            rows  = $urandom_range(5, 1);
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < width; c++) begin
                    send_element(t_sample'(base + c),
                                 (r == rows - 1 && $urandom_range(3, 0) == 0) ?
                                     t_node'($urandom()) : t_node'(r),
                                 random_float(), $urandom_range(3, 0) != 0,
                                 r == rows - 1);
                    sent++;
                end
            if ($urandom_range(9, 0) == 0) begin
                send_element(t_sample'($urandom()), t_node'($urandom()), $urandom(),
                             $urandom_range(1, 0), $urandom_range(1, 0));
                sent++;
            end
        end
    endtask

    // long receiver stall while items keep arriving
    task automatic test_backpressure();
        release_input();
        hold_off = 1'b1;
        repeat (2) @(posedge i_clk);
        hold_off = 1'b0;
        test_random(40);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_index = '0;
        in_ch.node_index = '0;
        in_ch.value_bits = '0;
        in_ch.node_enabled = 1'b0;
        in_ch.last_node = 1'b0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < SAMPLES; i++) begin
            peak_value[i] = '0;
            peak_node[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_gap_pct = 22; recv_gap_pct = 62;
        test_random(450);
        test_backpressure();
        send_gap_pct = 62; recv_gap_pct = 22;
        test_random(450);
        send_gap_pct = 0; recv_gap_pct = 0;
        test_random(400);
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[masked_column_argmax_unit] OK");
        else
            $display("[masked_column_argmax_unit] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[masked_column_argmax_unit] ERROR");
        $finish;
    end
endmodule
